// File: hdl/srrw_pkg.sv
package srrw_pkg;

    localparam int WINDOW_SLOTS_DEF = 32;
    localparam int ACK_BITS_DEF     = 32;
    localparam logic [3:0] IDLE_LIMIT_RESET = 4'd5;

    localparam logic [1:0] OP_META = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic [1:0] KIND_META_ACK  = 2'd0;
    localparam logic [1:0] KIND_RELEASE   = 2'd1;
    localparam logic [1:0] KIND_REPORT    = 2'd2;
    localparam logic [1:0] KIND_COMPLETE  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [31:0] file_id;
        logic [31:0] packet_total;
        logic [31:0] seq;
        logic [15:0] tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_file;
        logic [31:0] ack_source;
        logic [31:0] ack_dest;
        logic [31:0] first_seq;
        logic [31:0] last_seq;
        logic [5:0]  length;
        logic [31:0] bitmap;
        logic [15:0] out_tag;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SINGLE,
        S_RD,
        S_REL,
        S_DONE
    } t_state;

endpackage

// File: hdl/selective_repeat_receive_window_top.sv
// Receive window of a selective-repeat transfer, one session at a time. Meta
// items open or refresh the session and get a meta ack; data items land in a
// circular reorder window whose tags sit in a one-port-write, one-port-read
// memory, with a received bit per slot in flops; ticks give a window report or
// reset the session after the idle limit. Timing: an item is taken in one
// cycle and decoded in the next. Meta and tick results then pass S_SINGLE.
// A data item then walks the front of the window through the tag memory: each
// released packet takes a read state (S_RD) and an emit state (S_REL), and a
// completion result adds S_DONE. The input is stalled until the item's last
// result is in the output register; that register may still hold a result
// while the next item is taken. Output stall simply holds the walk in place.
module selective_repeat_receive_window_top #(
    parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF,
    parameter int ACK_BITS     = srrw_pkg::ACK_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  srrw_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output srrw_pkg::t_out_item o_out_item
);

    localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int USED_W = $clog2(WINDOW_SLOTS + 1);

    // control
    srrw_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic [3:0]       r_limit;

    // session
    logic              r_active, n_active;
    logic              r_meta_seen, n_meta_seen;
    logic [31:0]       r_file, n_file;
    logic [31:0]       r_source, n_source;
    logic [31:0]       r_dest, n_dest;
    logic [31:0]       r_total, n_total;
    logic [31:0]       r_expected, n_expected;
    logic [USED_W-1:0] r_used, n_used;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [WINDOW_SLOTS-1:0] r_recv, n_recv;
    logic [3:0]        r_idle, n_idle;

    // item and result holding
    srrw_pkg::t_in_item  r_item, n_item;
    srrw_pkg::t_out_item r_out, n_out;
    logic [1:0]          r_kind, n_kind;

    // tag memory port
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [15:0]       mem_rdata;

    // decode helpers
    logic [31:0]       seq_off;
    logic [SLOT_W:0]   wsum;
    logic [SLOT_W-1:0] phys_d;
    logic [SLOT_W:0]   hsum;
    logic [SLOT_W-1:0] head_next;
    logic [31:0]       bitmap;
    logic [5:0]        rep_len;
    logic [31:0]       exp_inc;
    logic              out_free;
    logic              do_clear;
    logic              id_match;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != srrw_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign seq_off  = r_item.seq - r_expected;
    assign id_match = (r_item.source_addr == r_source) && (r_item.file_id == r_file);
    assign exp_inc  = r_expected + 32'd1;

    // physical slot of window offset seq_off
    always_comb begin
        wsum = {1'b0, r_head} + {1'b0, seq_off[SLOT_W-1:0]};
        if (wsum >= (SLOT_W+1)'(WINDOW_SLOTS)) begin
            wsum = wsum - (SLOT_W+1)'(WINDOW_SLOTS);
        end
        phys_d = wsum[SLOT_W-1:0];
    end

    always_comb begin
        hsum = {1'b0, r_head} + (SLOT_W+1)'(1);
        if (hsum >= (SLOT_W+1)'(WINDOW_SLOTS)) begin
            hsum = hsum - (SLOT_W+1)'(WINDOW_SLOTS);
        end
        head_next = hsum[SLOT_W-1:0];
    end

    // report bitmap: logical slot i, unrolled over independent bits
    always_comb begin
        logic [SLOT_W:0] s;
        bitmap = '0;
        for (int i = 0; i < 32; i++) begin
            s = '0;
            if (i < WINDOW_SLOTS && i < ACK_BITS) begin
                s = {1'b0, r_head} + (SLOT_W+1)'(i);
                if (s >= (SLOT_W+1)'(WINDOW_SLOTS)) begin
                    s = s - (SLOT_W+1)'(WINDOW_SLOTS);
                end
                if (32'(i) < 32'(r_used)) begin
                    bitmap[i] = r_recv[s[SLOT_W-1:0]];
                end
            end
        end
    end

    assign rep_len = (32'(r_used) < 32'(ACK_BITS)) ? 6'(r_used) : 6'(ACK_BITS);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_active    = r_active;
        n_meta_seen = r_meta_seen;
        n_file      = r_file;
        n_source    = r_source;
        n_dest      = r_dest;
        n_total     = r_total;
        n_expected  = r_expected;
        n_used      = r_used;
        n_head      = r_head;
        n_recv      = r_recv;
        n_idle      = r_idle;
        n_item      = r_item;
        n_out       = r_out;
        n_kind      = r_kind;
        mem_we      = 1'b0;
        mem_waddr   = phys_d;
        do_clear    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            srrw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = srrw_pkg::S_EXEC;
                end
            end
            srrw_pkg::S_EXEC: begin
                n_state = srrw_pkg::S_IDLE;
                case (r_item.op)
                    srrw_pkg::OP_META: begin
                        if (!r_active || id_match) begin
                            if (!r_active) begin
                                n_active = 1'b1;
                                n_file   = r_item.file_id;
                                n_source = r_item.source_addr;
                            end
                            n_meta_seen = 1'b1;
                            n_dest      = r_item.dest_addr;
                            n_total     = r_item.packet_total;
                            n_idle      = '0;
                            n_kind      = srrw_pkg::KIND_META_ACK;
                            n_state     = srrw_pkg::S_SINGLE;
                        end
                    end
                    srrw_pkg::OP_DATA: begin
                        if (r_active && id_match) begin
                            n_idle = '0;
                            if (r_item.seq >= r_expected && seq_off < 32'(WINDOW_SLOTS)) begin
                                mem_we         = 1'b1;
                                n_recv[phys_d] = 1'b1;
                                if (seq_off >= 32'(r_used)) begin
                                    n_used = USED_W'(seq_off + 32'd1);
                                end
                                n_state = srrw_pkg::S_RD;
                            end
                        end
                    end
                    srrw_pkg::OP_TICK: begin
                        if (r_active) begin
                            if (r_idle == r_limit) begin
                                do_clear = 1'b1;
                            end else begin
                                n_idle = r_idle + 4'd1;
                                if (r_meta_seen) begin
                                    n_kind  = srrw_pkg::KIND_REPORT;
                                    n_state = srrw_pkg::S_SINGLE;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            srrw_pkg::S_SINGLE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = '0;
                    n_out.kind     = r_kind;
                    n_out.out_file = r_file;
                    n_out.last     = 1'b1;
                    if (r_kind == srrw_pkg::KIND_META_ACK) begin
                        n_out.ack_source = r_source;
                        n_out.ack_dest   = r_dest;
                    end else begin
                        n_out.first_seq = r_expected;
                        n_out.last_seq  = r_expected + 32'(r_used) - 32'd1;
                        if (r_used == '0) begin
                            n_out.last_seq = r_expected;
                        end
                        n_out.length = rep_len;
                        n_out.bitmap = bitmap;
                    end
                    n_state = srrw_pkg::S_IDLE;
                end
            end
            srrw_pkg::S_RD: begin
                // tag memory reads r_head this edge
                if (r_used != '0 && r_recv[r_head]) begin
                    n_state = srrw_pkg::S_REL;
                end else if (r_meta_seen && r_expected > r_total) begin
                    n_state = srrw_pkg::S_DONE;
                end else begin
                    n_state = srrw_pkg::S_IDLE;
                end
            end
            srrw_pkg::S_REL: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out          = '0;
                    n_out.kind     = srrw_pkg::KIND_RELEASE;
                    n_out.out_file = r_file;
                    n_out.first_seq = r_expected;
                    n_out.out_tag  = mem_rdata;
                    // last unless another release or a completion follows
                    n_out.last = !((r_used > USED_W'(1)) && r_recv[head_next])
                                 && !(r_meta_seen && exp_inc > r_total);
                    n_recv[r_head] = 1'b0;
                    n_head         = head_next;
                    n_expected     = exp_inc;
                    n_used         = r_used - USED_W'(1);
                    n_state        = srrw_pkg::S_RD;
                end
            end
            srrw_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out          = '0;
                    n_out.kind     = srrw_pkg::KIND_COMPLETE;
                    n_out.out_file = r_file;
                    n_out.last     = 1'b1;
                    do_clear       = 1'b1;
                    n_state        = srrw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srrw_pkg::S_IDLE;
            end
        endcase

        if (do_clear) begin
            n_active    = 1'b0;
            n_meta_seen = 1'b0;
            n_file      = '0;
            n_source    = '0;
            n_dest      = '0;
            n_total     = '0;
            n_expected  = 32'd1;
            n_used      = '0;
            n_head      = '0;
            n_recv      = '0;
            n_idle      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srrw_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_limit     <= srrw_pkg::IDLE_LIMIT_RESET;
            r_active    <= 1'b0;
            r_meta_seen <= 1'b0;
            r_file      <= '0;
            r_source    <= '0;
            r_dest      <= '0;
            r_total     <= '0;
            r_expected  <= 32'd1;
            r_used      <= '0;
            r_head      <= '0;
            r_recv      <= '0;
            r_idle      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            r_active    <= n_active;
            r_meta_seen <= n_meta_seen;
            r_file      <= n_file;
            r_source    <= n_source;
            r_dest      <= n_dest;
            r_total     <= n_total;
            r_expected  <= n_expected;
            r_used      <= n_used;
            r_head      <= n_head;
            r_recv      <= n_recv;
            r_idle      <= n_idle;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
        r_kind <= n_kind;
    end

    srrw_tag_mem #(
        .DEPTH (WINDOW_SLOTS),
        .AW    (SLOT_W)
    ) u_tag_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_item.tag),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

endmodule

// File: hdl/srrw_tag_mem.sv
module srrw_tag_mem #(
    parameter int DEPTH = srrw_pkg::WINDOW_SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/sv/selective_repeat_receive_window_top_test.sv
module selective_repeat_receive_window_top_test;

    localparam int SLOTS       = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 80;   // > one full release walk plus decode

    // clock, reset and block inputs, all known from time zero
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [3:0] i_cfg_data = '0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    srrw_pkg::t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    srrw_pkg::t_out_item o_out_item;

    always #10 i_clk = ~i_clk;

    selective_repeat_receive_window_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // ------------------------------------------------------------------
    // Window predictor: own copy of session state and the idle limit.
    // ------------------------------------------------------------------
    logic        sess_open;
    logic        sess_meta;
    logic [31:0] sess_file;
    logic [31:0] sess_src;
    logic [31:0] sess_dst;
    logic [31:0] sess_total;
    logic [31:0] next_seq;
    int          win_used;
    logic        win_rcvd [SLOTS];
    logic [15:0] win_tag  [SLOTS];
    logic [3:0]  tick_count;
    logic [3:0]  tick_limit;

    srrw_pkg::t_out_item pending_results [$];   // expected results, oldest first
    int          errors = 0;
    int          pushed_count = 0;              // results queued by the last item

    function automatic srrw_pkg::t_out_item blank_result(logic [1:0] kind);
        srrw_pkg::t_out_item r;
        r          = '0;
        r.kind     = kind;
        r.out_file = sess_file;
        return r;
    endfunction

    task automatic drop_session();
        sess_open  = 1'b0;
        sess_meta  = 1'b0;
        sess_file  = '0;
        sess_src   = '0;
        sess_dst   = '0;
        sess_total = '0;
        next_seq   = 32'd1;
        win_used   = 0;
        for (int i = 0; i < SLOTS; i++) begin
            win_rcvd[i] = 1'b0;
            win_tag[i]  = '0;
        end
        tick_count = '0;
    endtask

    // Works out the results of one accepted item and queues them.
    task automatic predict_window(srrw_pkg::t_in_item it);
        srrw_pkg::t_out_item r;
        logic [31:0] offset;
        logic [31:0] bits;
        int          n;
        int          d;
        int          len;
        n = 0;
        case (it.op)
            srrw_pkg::OP_META: begin
                if (!sess_open) begin
                    sess_open = 1'b1;
                    sess_file = it.file_id;
                    sess_src  = it.source_addr;
                end else if (it.source_addr != sess_src || it.file_id != sess_file) begin
                    return;   // foreign meta
                end
                sess_meta    = 1'b1;
                sess_dst     = it.dest_addr;
                sess_total   = it.packet_total;
                tick_count   = '0;
                r            = blank_result(srrw_pkg::KIND_META_ACK);
                r.ack_source = sess_src;
                r.ack_dest   = sess_dst;
                r.last       = 1'b1;
                pending_results.push_back(r);
            end
            srrw_pkg::OP_DATA: begin
                if (!sess_open || it.source_addr != sess_src || it.file_id != sess_file)
                    return;
                tick_count = '0;
                if (it.seq < next_seq)
                    return;   // stale
                offset = it.seq - next_seq;
                if (offset >= SLOTS)
                    return;   // beyond window, silent drop
                d = int'(offset);
                if (d >= win_used) begin
                    for (int i = win_used; i < d; i++)
                        win_rcvd[i] = 1'b0;
                    win_used = d + 1;
                end
                win_rcvd[d] = 1'b1;
                win_tag[d]  = it.tag;
                while (win_used > 0 && win_rcvd[0]) begin
                    r           = blank_result(srrw_pkg::KIND_RELEASE);
                    r.first_seq = next_seq;
                    r.out_tag   = win_tag[0];
                    pending_results.push_back(r);
                    n++;
                    next_seq = next_seq + 32'd1;
                    for (int i = 0; i < SLOTS - 1; i++) begin
                        win_rcvd[i] = win_rcvd[i+1];
                        win_tag[i]  = win_tag[i+1];
                    end
                    win_rcvd[SLOTS-1] = 1'b0;
                    win_tag[SLOTS-1]  = '0;
                    win_used--;
                end
                if (sess_meta && next_seq > sess_total) begin
                    pending_results.push_back(blank_result(srrw_pkg::KIND_COMPLETE));
                    n++;
                    drop_session();
                end
                if (n > 0)
                    pending_results[$].last = 1'b1;
            end
            srrw_pkg::OP_TICK: begin
                if (!sess_open)
                    return;
                if (tick_count == tick_limit) begin
                    drop_session();
                    return;
                end
                tick_count = tick_count + 4'd1;
                if (!sess_meta)
                    return;
                len  = (win_used < 32) ? win_used : 32;
                bits = '0;
                for (int i = 0; i < len; i++)
                    if (win_rcvd[i])
                        bits[i] = 1'b1;
                r           = blank_result(srrw_pkg::KIND_REPORT);
                r.first_seq = next_seq;
                r.last_seq  = (win_used > 0) ? next_seq + win_used - 1 : next_seq;
                r.length    = len[5:0];
                r.bitmap    = bits;
                r.last      = 1'b1;
                pending_results.push_back(r);
            end
            default: ;   // op 3 ignored
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: checks each result taken from the block, stalls in random bursts.
    // ------------------------------------------------------------------
    logic      quiet     = 1'b0;   // no idling on either side
    logic      hold_req  = 1'b0;   // asks for one long receiver hold-off
    int        hold_left = 0;
    int        burst_left = 0;
    int        free_left  = 0;
    srrw_pkg::t_out_item want;

    task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("kind: expected no result, got %0d", o_out_item.kind);
                errors++;
            end else begin
                want = pending_results.pop_front();
                cmp_field("kind",       32'(want.kind),    32'(o_out_item.kind));
                cmp_field("out_file",   want.out_file,     o_out_item.out_file);
                cmp_field("ack_source", want.ack_source,   o_out_item.ack_source);
                cmp_field("ack_dest",   want.ack_dest,     o_out_item.ack_dest);
                cmp_field("first_seq",  want.first_seq,    o_out_item.first_seq);
                cmp_field("last_seq",   want.last_seq,     o_out_item.last_seq);
                cmp_field("length",     32'(want.length),  32'(o_out_item.length));
                cmp_field("bitmap",     want.bitmap,       o_out_item.bitmap);
                cmp_field("out_tag",    32'(want.out_tag), 32'(o_out_item.out_tag));
                cmp_field("last",       32'(want.last),    32'(o_out_item.last));
            end
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 1)) begin
            burst_left = $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            free_left = $urandom_range(0, 29);
            i_out_stall <= 1'b0;
        end
    end

    // watchdog
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("selective_repeat_receive_window_top_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    int items_sent = 0;

    // Offers one item, with an optional gap first; valid stays high after.
    task automatic send_item(srrw_pkg::t_in_item it);
        int queued;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        queued = pending_results.size();
        predict_window(it);
        pushed_count = pending_results.size() - queued;
        items_sent++;
    endtask

    // Let every expected item drain, then let a silent walk finish.
    task automatic drain_all();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [3:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tick_limit = v;
    endtask

    function automatic srrw_pkg::t_in_item mk_item(logic [1:0] op, logic [31:0] src,
                                                   logic [31:0] dst, logic [31:0] fid,
                                                   logic [31:0] tot, logic [31:0] seq,
                                                   logic [15:0] tag);
        srrw_pkg::t_in_item it;
        it.op           = op;
        it.source_addr  = src;
        it.dest_addr    = dst;
        it.file_id      = fid;
        it.packet_total = tot;
        it.seq          = seq;
        it.tag          = tag;
        return it;
    endfunction

    typedef struct {
        srrw_pkg::t_in_item  item;
        logic                typed;   // expected result written out in the row
        srrw_pkg::t_out_item res;
    } t_row;

    t_row rows [$];

    task automatic add_row(srrw_pkg::t_in_item it);
        t_row row;
        row.item  = it;
        row.typed = 1'b0;
        row.res   = '0;
        rows.push_back(row);
    endtask

    task automatic add_typed(srrw_pkg::t_in_item it, srrw_pkg::t_out_item res);
        t_row row;
        row.item  = it;
        row.typed = 1'b1;
        row.res   = res;
        rows.push_back(row);
    endtask

    // Random item for an open session: mostly near the window front.
    function automatic srrw_pkg::t_in_item rand_session_item(logic [31:0] src,
                                                             logic [31:0] fid);
        srrw_pkg::t_in_item it;
        logic [31:0] seq;
        int          pick;
        pick = $urandom_range(0, 99);
        seq  = next_seq + $urandom_range(0, 6);
        if (pick < 8)
            seq = next_seq + $urandom_range(0, 40);       // window edge and beyond
        else if (pick < 13 && next_seq > 1)
            seq = next_seq - $urandom_range(1, 3);        // stale
        it = mk_item(srrw_pkg::OP_DATA, src, $urandom, fid, $urandom, seq, 16'($urandom));
        if (pick >= 90 && pick < 95)
            it.op = srrw_pkg::OP_TICK;
        else if (pick >= 95 && pick < 97)
            it.source_addr = src ^ (32'd1 << $urandom_range(0, 31));   // foreign
        else if (pick == 97)
            it.op = srrw_pkg::OP_RSVD;                                // unknown op
        else if (pick >= 98)
            it = mk_item(srrw_pkg::OP_META, src, $urandom, fid, sess_total, $urandom,
                         16'($urandom));
        return it;
    endfunction

    initial begin
        srrw_pkg::t_out_item r;
        logic [31:0] src;
        logic [31:0] fid;
        logic [31:0] tot;
        int          steps;
        int          held;

        tick_limit = srrw_pkg::IDLE_LIMIT_RESET;
        drop_session();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed table (idle limit at reset value) ----
        r = '0;
        r.kind = srrw_pkg::KIND_META_ACK; r.out_file = 32'h1234; r.ack_source = 32'h0A000001;
        r.ack_dest = 32'hC0A80001; r.last = 1'b1;
        add_typed(mk_item(srrw_pkg::OP_META, 32'h0A000001, 32'hC0A80001, 32'h1234, 5, 0, 0), r);
        r = '0;
        r.kind = srrw_pkg::KIND_REPORT; r.out_file = 32'h1234; r.first_seq = 1; r.last_seq = 1;
        r.last = 1'b1;
        add_typed(mk_item(srrw_pkg::OP_TICK, 0, 0, 0, 0, 0, 0), r);          // empty window
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h0A000001, 0, 32'h1234, 0, 3, 16'h0003)); // gap
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h0A000001, 0, 32'h1234, 0, 2, 16'h0002));
        add_row(mk_item(srrw_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h0A000002, 0, 32'h1234, 0, 1, 16'h0bad)); // foreign
        add_row(mk_item(srrw_pkg::OP_META, 32'h0A000001, 0, 32'h9999, 7, 0, 0));  // foreign meta
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h0A000001, 0, 32'h1234, 0, 0, 16'h0bad)); // stale
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h0A000001, 0, 32'h1234, 0, 33, 16'h0bad)); // beyond
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h0A000001, 0, 32'h1234, 0, 3, 16'h0033)); // dup
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h0A000001, 0, 32'h1234, 0, 1, 16'h0001)); // 1..3
        add_row(mk_item(srrw_pkg::OP_RSVD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0,
                        16'hFFFF));
        add_row(mk_item(srrw_pkg::OP_META, 32'h0A000001, 32'h0, 32'h1234, 4, 0, 0)); // refresh
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h0A000001, 0, 32'h1234, 0, 4, 16'hFFFF)); // done
        add_row(mk_item(srrw_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));                // no session
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h1, 0, 32'h1, 0, 1, 16'h1));    // no session
        add_row(mk_item(srrw_pkg::OP_META, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 0, 0, 0)); // zero
        add_row(mk_item(srrw_pkg::OP_DATA, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0, 1, 16'h0000));
        add_row(mk_item(srrw_pkg::OP_META, 32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 0, 0));
        add_row(mk_item(srrw_pkg::OP_DATA, 32'h0, 0, 32'h0, 0, 32, 16'h0000)); // last slot
        add_row(mk_item(srrw_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));                // full length
        repeat (6) add_row(mk_item(srrw_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));     // idle limit

        foreach (rows[k]) begin
            send_item(rows[k].item);
            if (rows[k].typed) begin
                // replace the computed entry with the one written in the table
                repeat (pushed_count) pending_results.pop_back();
                pending_results.push_back(rows[k].res);
            end
        end
        drain_all();

        // ---------------- random sessions ----------------
        held = 0;
        while (items_sent < 150) begin
            case ($urandom_range(0, 3))
                0: write_limit(4'd1);
                1: write_limit(4'd15);
                default: write_limit(4'($urandom_range(1, 15)));
            endcase
            src = $urandom;
            fid = $urandom;
            tot = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 30);
            if ($urandom_range(0, 9) == 0)   // data ahead of meta
                send_item(mk_item(srrw_pkg::OP_DATA, src, $urandom, fid, 0, 1, 16'($urandom)));
            send_item(mk_item(srrw_pkg::OP_META, src, $urandom, fid, tot, $urandom,
                              16'($urandom)));
            steps = 0;
            while (sess_open && steps < 50 && items_sent < 150) begin
                if (!held && items_sent > 80) begin
                    held     = 1;
                    hold_req = 1'b1;   // receiver backs up, sender keeps going
                end
                if (items_sent > 150 - 30)
                    quiet = 1'b1;
                send_item(rand_session_item(src, fid));
                steps++;
            end
            while (sess_open)
                send_item(mk_item(srrw_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, 16'($urandom)));
            drain_all();
        end

        // ---------------- end of run ----------------
        drain_all();
        if (pending_results.size() != 0) begin
            $error("kind: %0d results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("selective_repeat_receive_window_top_test passed");
        else
            $display("selective_repeat_receive_window_top_test failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/srrw_pkg.sv
hdl/srrw_tag_mem.sv
hdl/selective_repeat_receive_window_top.sv
tb/sv/selective_repeat_receive_window_top_test.sv
